[rtl/pipr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pipr_pkg: shared types and constants for the point-in-polygon ring test
// control flags that travel with each vertex, register map and queue sizes
// ----------------------------------------------------------------------------
package pipr_pkg;

  // flags that the front end attaches to every vertex
  typedef struct packed {
    logic e1_valid;  // an edge from the previous vertex exists
    logic rend;      // last vertex of its ring, closing edge is tested
    logic ring_ok;   // ring has reached the minimum vertex count
    logic send;      // last vertex of the set, a result is produced
  } ctrl_t;

  localparam logic [1:0] RING_MIN_VERTICES = 2'd3;

  // configuration port
  localparam int          CFG_ADDR_WIDTH = 3;
  localparam int          CFG_DATA_WIDTH = 32;
  localparam logic        CFG_EPS_INDEX  = 1'b0;
  localparam int          EPS_WIDTH      = 31;
  localparam logic [30:0] EPS_RESET      = 31'd419;

  // queue sizes
  localparam int QUEUE_DEPTH = 4;
  localparam int OUT_DEPTH   = 4;
  localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

endpackage

[rtl/pipr_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pipr_fifo: small synchronous queue
// register array with read and write pointers, depth a power of two
// ----------------------------------------------------------------------------
module pipr_fifo #(
  parameter int  DATA_WIDTH = 8,
  parameter int  DEPTH      = 4,
  localparam int CNT_W      = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [DATA_WIDTH-1:0] wr_data,
  input  logic                  rd_en,
  output logic [DATA_WIDTH-1:0] rd_data,
  output logic                  full,
  output logic                  empty,
  output logic [CNT_W-1:0]      count
);

  localparam int PTR_W = $clog2(DEPTH);

  logic [DATA_WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  do_wr, do_rd;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign count   = count_r;
  assign rd_data = mem_r[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

[rtl/pipr_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pipr_front: vertex intake and ring tracking
// latches the query point, keeps previous and first vertex, counts vertices
// ----------------------------------------------------------------------------
module pipr_front #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic signed [COORD_WIDTH-1:0] in_query_x,
  input  logic signed [COORD_WIDTH-1:0] in_query_y,
  input  logic signed [COORD_WIDTH-1:0] in_vertex_x,
  input  logic signed [COORD_WIDTH-1:0] in_vertex_y,
  input  logic                          in_ring_end,
  input  logic                          in_set_end,
  output logic [8*COORD_WIDTH-1:0]      q_data,
  output pipr_pkg::ctrl_t               q_ctrl
);

  import pipr_pkg::*;

  logic                   set_start_r, set_start_nxt;
  logic [1:0]             cnt_r, cnt_nxt, cnt_after;
  logic [COORD_WIDTH-1:0] held_qx_r, held_qy_r, prev_x_r, prev_y_r, first_x_r, first_y_r;
  logic [COORD_WIDTH-1:0] qx_use, qy_use, fx_use, fy_use;
  logic                   rend;

  always_comb begin
    rend      = in_ring_end || in_set_end;
    cnt_after = (cnt_r == RING_MIN_VERTICES) ? cnt_r : cnt_r + 2'd1;
    qx_use    = set_start_r ? in_query_x : held_qx_r;
    qy_use    = set_start_r ? in_query_y : held_qy_r;
    fx_use    = (cnt_r == 2'd0) ? in_vertex_x : first_x_r;
    fy_use    = (cnt_r == 2'd0) ? in_vertex_y : first_y_r;

    q_ctrl.e1_valid = (cnt_r != 2'd0);
    q_ctrl.rend     = rend;
    q_ctrl.ring_ok  = (cnt_after == RING_MIN_VERTICES);
    q_ctrl.send     = in_set_end;
    q_data = {qy_use, qx_use, fy_use, fx_use, prev_y_r, prev_x_r, in_vertex_y, in_vertex_x};

    set_start_nxt = accept ? in_set_end : set_start_r;
    cnt_nxt       = cnt_r;
    if (accept) begin
      cnt_nxt = rend ? 2'd0 : cnt_after;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_start_r <= 1'b1;
      cnt_r       <= 2'd0;
    end else begin
      set_start_r <= set_start_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_qx_r <= qx_use;
      held_qy_r <= qy_use;
      prev_x_r  <= in_vertex_x;
      prev_y_r  <= in_vertex_y;
      first_x_r <= fx_use;
      first_y_r <= fy_use;
    end
  end

endmodule

[rtl/pipr_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pipr_back: edge crossing pipeline
// differences, cross products, sign-aware compare, parity and hit tracking
// ----------------------------------------------------------------------------
module pipr_back #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [pipr_pkg::EPS_WIDTH-1:0]  edge_eps,
  input  logic                            q_empty,
  input  logic [8*COORD_WIDTH-1:0]        q_data,
  input  pipr_pkg::ctrl_t                 q_ctrl,
  output logic                            q_pop,
  input  logic [pipr_pkg::OUT_CNT_W-1:0]  res_count,
  output logic                            res_push,
  output logic                            res_data
);

  import pipr_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;
  localparam int CW = (DW > EPS_WIDTH) ? DW : EPS_WIDTH;

  // unpacked queue head
  logic signed [W-1:0] vx, vy, px, py, fx, fy, qx, qy;

  // stage 1
  logic                 s1_v_r, s1_v_nxt;
  ctrl_t                s1_ctrl_r;
  logic signed [DW-1:0] s1_d1_r, s1_qx1_r, s1_bx1_r, s1_qy1_r;
  logic signed [DW-1:0] s1_d2_r, s1_qx2_r, s1_bx2_r, s1_qy2_r;
  logic signed [DW-1:0] s1_d1_nxt, s1_qx1_nxt, s1_bx1_nxt, s1_qy1_nxt;
  logic signed [DW-1:0] s1_d2_nxt, s1_qx2_nxt, s1_bx2_nxt, s1_qy2_nxt;
  logic                 s1_str1_r, s1_str2_r, s1_str1_nxt, s1_str2_nxt;

  // stage 2
  logic                 s2_v_r;
  ctrl_t                s2_ctrl_r;
  logic signed [PW-1:0] s2_lhs1_r, s2_rhs1_r, s2_lhs2_r, s2_rhs2_r;
  logic signed [PW-1:0] s2_lhs1_nxt, s2_rhs1_nxt, s2_lhs2_nxt, s2_rhs2_nxt;
  logic                 s2_dpos1_r, s2_dpos2_r, s2_chk1_r, s2_chk2_r;
  logic                 s2_dpos1_nxt, s2_dpos2_nxt, s2_chk1_nxt, s2_chk2_nxt;
  logic [DW-1:0]        mag1, mag2;

  // stage 3
  logic                 parity_r, parity_nxt, any_hit_r, any_hit_nxt;
  logic                 c1, c2, par, hit;

  logic [OUT_CNT_W:0]   reserved;

  function automatic logic signed [DW-1:0] sdiff(logic signed [W-1:0] a,
                                                 logic signed [W-1:0] b);
    sdiff = DW'(a) - DW'(b);
  endfunction

  always_comb begin
    vx = q_data[0*W +: W];
    vy = q_data[1*W +: W];
    px = q_data[2*W +: W];
    py = q_data[3*W +: W];
    fx = q_data[4*W +: W];
    fy = q_data[5*W +: W];
    qx = q_data[6*W +: W];
    qy = q_data[7*W +: W];
  end

  // hold a set end back while the result queue could overflow
  always_comb begin
    reserved = (OUT_CNT_W + 1)'(res_count)
             + (OUT_CNT_W + 1)'(s1_v_r && s1_ctrl_r.send)
             + (OUT_CNT_W + 1)'(s2_v_r && s2_ctrl_r.send);
    q_pop    = !q_empty && !(q_ctrl.send && (reserved >= (OUT_CNT_W + 1)'(OUT_DEPTH)));
    s1_v_nxt = q_pop;
  end

  // stage 1: edge from previous to current, and closing edge to first vertex
  always_comb begin
    s1_d1_nxt   = sdiff(py, vy);
    s1_qx1_nxt  = sdiff(qx, vx);
    s1_bx1_nxt  = sdiff(px, vx);
    s1_qy1_nxt  = sdiff(qy, vy);
    s1_str1_nxt = (vy > qy) != (py > qy);
    s1_d2_nxt   = sdiff(vy, fy);
    s1_qx2_nxt  = sdiff(qx, fx);
    s1_bx2_nxt  = sdiff(vx, fx);
    s1_qy2_nxt  = sdiff(qy, fy);
    s1_str2_nxt = (fy > qy) != (vy > qy);
  end

  // stage 2: products and height filter
  always_comb begin
    mag1         = s1_d1_r[DW-1] ? DW'(-s1_d1_r) : DW'(s1_d1_r);
    mag2         = s1_d2_r[DW-1] ? DW'(-s1_d2_r) : DW'(s1_d2_r);
    s2_lhs1_nxt  = s1_qx1_r * s1_d1_r;
    s2_rhs1_nxt  = s1_bx1_r * s1_qy1_r;
    s2_lhs2_nxt  = s1_qx2_r * s1_d2_r;
    s2_rhs2_nxt  = s1_bx2_r * s1_qy2_r;
    s2_dpos1_nxt = !s1_d1_r[DW-1] && (s1_d1_r != '0);
    s2_dpos2_nxt = !s1_d2_r[DW-1] && (s1_d2_r != '0);
    s2_chk1_nxt  = s1_ctrl_r.e1_valid && s1_str1_r && !(CW'(mag1) < CW'(edge_eps));
    s2_chk2_nxt  = s1_ctrl_r.rend && s1_str2_r && !(CW'(mag2) < CW'(edge_eps));
  end

  // stage 3: crossing decision, parity and set result
  always_comb begin
    c1  = s2_chk1_r && (s2_dpos1_r ? (s2_lhs1_r < s2_rhs1_r) : (s2_rhs1_r < s2_lhs1_r));
    c2  = s2_chk2_r && (s2_dpos2_r ? (s2_lhs2_r < s2_rhs2_r) : (s2_rhs2_r < s2_lhs2_r));
    par = parity_r ^ c1 ^ c2;
    hit = any_hit_r;
    parity_nxt  = parity_r;
    any_hit_nxt = any_hit_r;
    if (s2_v_r) begin
      parity_nxt = par;
      if (s2_ctrl_r.rend) begin
        hit        = any_hit_r || (s2_ctrl_r.ring_ok && par);
        parity_nxt = 1'b0;
      end
      any_hit_nxt = s2_ctrl_r.send ? 1'b0 : hit;
    end
    res_push = s2_v_r && s2_ctrl_r.send;
    res_data = hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      parity_r  <= 1'b0;
      any_hit_r <= 1'b0;
    end else begin
      s1_v_r    <= s1_v_nxt;
      s2_v_r    <= s1_v_r;
      parity_r  <= parity_nxt;
      any_hit_r <= any_hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_ctrl_r  <= q_ctrl;
    s1_d1_r    <= s1_d1_nxt;
    s1_qx1_r   <= s1_qx1_nxt;
    s1_bx1_r   <= s1_bx1_nxt;
    s1_qy1_r   <= s1_qy1_nxt;
    s1_str1_r  <= s1_str1_nxt;
    s1_d2_r    <= s1_d2_nxt;
    s1_qx2_r   <= s1_qx2_nxt;
    s1_bx2_r   <= s1_bx2_nxt;
    s1_qy2_r   <= s1_qy2_nxt;
    s1_str2_r  <= s1_str2_nxt;
    s2_ctrl_r  <= s1_ctrl_r;
    s2_lhs1_r  <= s2_lhs1_nxt;
    s2_rhs1_r  <= s2_rhs1_nxt;
    s2_lhs2_r  <= s2_lhs2_nxt;
    s2_rhs2_r  <= s2_rhs2_nxt;
    s2_dpos1_r <= s2_dpos1_nxt;
    s2_dpos2_r <= s2_dpos2_nxt;
    s2_chk1_r  <= s2_chk1_nxt;
    s2_chk2_r  <= s2_chk2_nxt;
  end

endmodule

[rtl/point_in_polygon_rings_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_polygon_rings_top: even-odd point-in-polygon test over ring sets
// vertices stream in, one result per set tells whether any ring holds the point
// ----------------------------------------------------------------------------
// usage
//   input queue: drive in_* and push; a vertex request is taken at a clock
//     edge with push high and full low. the query point is sampled on the
//     first vertex of a set. ring_end closes a ring, set_end closes the set.
//   result queue: while empty is low, out_inside_any holds the oldest result;
//     pop high takes it. only set_end vertices produce a result.
//   config: apb-style write of edge_epsilon at byte address 0, pready tied
//     high; write only while the block is idle.
//   throughput: one vertex per cycle unless a set end waits for result room;
//     four multipliers test the running edge and at ring ends the closing edge.
//   result path: a set_end vertex passes the queue write, difference stage,
//     product stage and result queue write before its result shows.
//   reset: rst_n low for one clock empties both queues, clears ring state
//     and loads edge_epsilon with 419.
//   stall: while pop stays low, results pile up in a 4-entry queue; a set end
//     waits in the 4-entry input queue while that result queue has no room,
//     and full rises once the input queue fills.
// ----------------------------------------------------------------------------
module point_in_polygon_rings_top #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input queue
  input  logic                                  push,
  output logic                                  full,
  input  logic signed [COORD_WIDTH-1:0]         in_query_x,
  input  logic signed [COORD_WIDTH-1:0]         in_query_y,
  input  logic signed [COORD_WIDTH-1:0]         in_vertex_x,
  input  logic signed [COORD_WIDTH-1:0]         in_vertex_y,
  input  logic                                  in_ring_end,
  input  logic                                  in_set_end,
  // result queue
  output logic                                  empty,
  input  logic                                  pop,
  output logic                                  out_inside_any,
  // configuration
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [pipr_pkg::CFG_ADDR_WIDTH-1:0]   paddr,
  input  logic [pipr_pkg::CFG_DATA_WIDTH-1:0]   pwdata,
  output logic [pipr_pkg::CFG_DATA_WIDTH-1:0]   prdata,
  output logic                                  pready
);

  import pipr_pkg::*;

  localparam int QW = 8 * COORD_WIDTH + $bits(ctrl_t);

  // configuration register
  logic [EPS_WIDTH-1:0] edge_eps_r, edge_eps_nxt;
  logic                 cfg_wr;
  logic                 cfg_hit;

  // front to back queue
  logic                        accept;
  logic [8*COORD_WIDTH-1:0]    fr_data;
  ctrl_t                       fr_ctrl;
  logic [QW-1:0]               q_rd;
  logic                        q_empty, q_pop;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;
  ctrl_t                       q_ctrl;

  // result queue
  logic                 res_push, res_data;
  logic [OUT_CNT_W-1:0] res_count;
  logic                 res_full;

  // apb register: word index is the top address bit
  assign pready  = 1'b1;
  assign cfg_hit = (paddr[CFG_ADDR_WIDTH-1] == CFG_EPS_INDEX);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = cfg_hit ? CFG_DATA_WIDTH'(edge_eps_r) : '0;

  always_comb begin
    edge_eps_nxt = edge_eps_r;
    if (cfg_wr && cfg_hit) begin
      edge_eps_nxt = pwdata[EPS_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_eps_r <= EPS_RESET;
    end else begin
      edge_eps_r <= edge_eps_nxt;
    end
  end

  // vertex request taken
  assign accept = push && !full;

  pipr_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .in_query_x  (in_query_x),
    .in_query_y  (in_query_y),
    .in_vertex_x (in_vertex_x),
    .in_vertex_y (in_vertex_y),
    .in_ring_end (in_ring_end),
    .in_set_end  (in_set_end),
    .q_data      (fr_data),
    .q_ctrl      (fr_ctrl)
  );

  // decouples intake from the crossing pipeline
  pipr_fifo #(
    .DATA_WIDTH (QW),
    .DEPTH      (QUEUE_DEPTH)
  ) u_vtx_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept),
    .wr_data ({fr_ctrl, fr_data}),
    .rd_en   (q_pop),
    .rd_data (q_rd),
    .full    (full),
    .empty   (q_empty),
    .count   (q_count)
  );

  assign q_ctrl = ctrl_t'(q_rd[QW-1 -: $bits(ctrl_t)]);

  pipr_back #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .edge_eps  (edge_eps_r),
    .q_empty   (q_empty),
    .q_data    (q_rd[8*COORD_WIDTH-1:0]),
    .q_ctrl    (q_ctrl),
    .q_pop     (q_pop),
    .res_count (res_count),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  // result queue, space is reserved by the back end before a set end enters
  pipr_fifo #(
    .DATA_WIDTH (1),
    .DEPTH      (OUT_DEPTH)
  ) u_res_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res_data),
    .rd_en   (pop),
    .rd_data (out_inside_any),
    .full    (res_full),
    .empty   (empty),
    .count   (res_count)
  );

  // occupancy of the vertex queue and result full flag are not needed here
  logic unused_ok;
  assign unused_ok = ^{q_count, res_full};

endmodule
